FILE: hw/rtl/spmm_pkg.sv
// Shared types and constants for the stereo peak mipmap builder.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package spmm_pkg;

    localparam int NUM_LEVELS = 3;
    localparam int LEVEL_W    = 2;
    localparam int SAMPLE_W   = 16;
    localparam int PEAK_IDX_W = 14;
    localparam int FILL_W     = 13;
    localparam int FRAME_W    = 21;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int Q_CNT_W    = 3;

    localparam logic [FRAME_W-1:0] MAX_FRAMES = 21'd1048576;

    // Block length per level, index 0 is the finest level
    localparam logic [NUM_LEVELS-1:0][FILL_W-1:0] BLOCK_LEN =
        {13'd4096, 13'd512, 13'd64};

    localparam logic signed [SAMPLE_W-1:0] PEAK_LOW  = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] PEAK_HIGH = 16'sh7FFF;

    // Register word indexes on the configuration port
    localparam logic REG_MONO_INPUT = 1'b0;

    typedef struct packed {
        logic [PEAK_IDX_W-1:0]      peak_index;
        logic signed [SAMPLE_W-1:0] max_peak;
        logic signed [SAMPLE_W-1:0] min_peak;
    } spmm_peak_t;

    // All results caused by one frame
    typedef struct packed {
        logic [NUM_LEVELS-1:0]              emit;
        logic                               overflow;
        spmm_peak_t [NUM_LEVELS-1:0]        peak;
    } spmm_bundle_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } spmm_q_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/stereo_peak_mipmap_builder.sv
// Top level of the stereo peak mipmap builder: configuration register and
// the front end, bundle queue and back end. Depends on spmm_pkg.
`default_nettype none

// Min/max peak decimation of a stereo stream. Each transaction on the input
// channel is one frame; the block forms mid = floor((left + right) / 2), or
// uses the left sample alone when mono_input is set, and tracks running
// extremes at three levels with blocks of 64, 512 and 4096 frames. A level
// whose block fills, or any non-empty level on an end-of-buffer frame, gives
// one result transaction; results of one frame come in ascending level and
// the final one carries last. Frames beyond 1048576 in a buffer are dropped
// and flag overflow until the buffer ends. Throughput is one frame per clock
// cycle while in_stall is low: the front end updates all levels at once and
// pushes a bundle of that frame's results into a four-entry queue. The back
// end drains one result per cycle while out_stall is low; in_stall rises only
// when the queue is full. With the queue and output register empty, the
// first result of a frame is valid from the clock edge after the one that
// accepts the frame. Write mono_input only while idle.
module stereo_peak_mipmap_builder (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // configuration port
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [2:0]                             paddr,
    input  wire logic [31:0]                            pwdata,
    output logic [31:0]                                 prdata,
    output logic                                        pready,
    // frame input
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [spmm_pkg::SAMPLE_W-1:0]   left_sample,
    input  wire logic signed [spmm_pkg::SAMPLE_W-1:0]   right_sample,
    input  wire logic                                   end_of_buffer,
    // result output
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [spmm_pkg::LEVEL_W-1:0]                level,
    output logic [spmm_pkg::PEAK_IDX_W-1:0]             peak_index,
    output logic signed [spmm_pkg::SAMPLE_W-1:0]        max_peak,
    output logic signed [spmm_pkg::SAMPLE_W-1:0]        min_peak,
    output logic                                        overflow,
    output logic                                        last
);

    logic                      mono_reg;
    logic                      cfg_write;
    logic                      accept;
    logic                      push;
    logic                      pop;
    spmm_pkg::spmm_bundle_t    push_bundle;
    spmm_pkg::spmm_bundle_t    head_bundle;
    spmm_pkg::spmm_q_stat_t    q_stat;

    // Word address lives in paddr[2]; byte lanes are ignored
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                    && (paddr[2] == spmm_pkg::REG_MONO_INPUT);
    assign prdata    = (paddr[2] == spmm_pkg::REG_MONO_INPUT)
                     ? {31'b0, mono_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mono_reg <= 1'b0;
        else if (cfg_write)
            mono_reg <= pwdata[0];
    end

    // Hold the input off only while the queue has no free entry
    assign in_stall = q_stat.full;
    assign accept   = in_valid && !in_stall;

    spmm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .mono          (mono_reg),
        .accept        (accept),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .end_of_buffer (end_of_buffer),
        .bundle        (push_bundle),
        .push          (push)
    );

    spmm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_bundle),
        .pop       (pop),
        .head      (head_bundle),
        .stat      (q_stat)
    );

    spmm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_bundle),
        .q_stat     (q_stat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .level      (level),
        .peak_index (peak_index),
        .max_peak   (max_peak),
        .min_peak   (min_peak),
        .overflow   (overflow),
        .last       (last)
    );

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (level < spmm_pkg::LEVEL_W'(spmm_pkg::NUM_LEVELS)))
        else $error("result level out of range");

endmodule

`default_nettype wire

FILE: hw/rtl/spmm_front.sv
// Front end: forms the mid value, updates per-level running extremes and
// fills, and builds one result bundle per frame. Depends on spmm_pkg.
`default_nettype none

module spmm_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  mono,
    input  wire logic                                  accept,
    input  wire logic signed [spmm_pkg::SAMPLE_W-1:0]  left_sample,
    input  wire logic signed [spmm_pkg::SAMPLE_W-1:0]  right_sample,
    input  wire logic                                  end_of_buffer,
    output spmm_pkg::spmm_bundle_t                     bundle,
    output logic                                       push
);

    logic [spmm_pkg::FILL_W-1:0]            fill_reg    [spmm_pkg::NUM_LEVELS];
    logic [spmm_pkg::FILL_W-1:0]            fill_next   [spmm_pkg::NUM_LEVELS];
    logic [spmm_pkg::FILL_W-1:0]            fill_upd    [spmm_pkg::NUM_LEVELS];
    logic signed [spmm_pkg::SAMPLE_W-1:0]   max_reg     [spmm_pkg::NUM_LEVELS];
    logic signed [spmm_pkg::SAMPLE_W-1:0]   max_next    [spmm_pkg::NUM_LEVELS];
    logic signed [spmm_pkg::SAMPLE_W-1:0]   max_upd     [spmm_pkg::NUM_LEVELS];
    logic signed [spmm_pkg::SAMPLE_W-1:0]   min_reg     [spmm_pkg::NUM_LEVELS];
    logic signed [spmm_pkg::SAMPLE_W-1:0]   min_next    [spmm_pkg::NUM_LEVELS];
    logic signed [spmm_pkg::SAMPLE_W-1:0]   min_upd     [spmm_pkg::NUM_LEVELS];
    logic [spmm_pkg::PEAK_IDX_W-1:0]        pcnt_reg    [spmm_pkg::NUM_LEVELS];
    logic [spmm_pkg::PEAK_IDX_W-1:0]        pcnt_next   [spmm_pkg::NUM_LEVELS];
    logic [spmm_pkg::FRAME_W-1:0]           frame_count_reg;
    logic [spmm_pkg::FRAME_W-1:0]           frame_count_next;
    logic                                   ovf_reg;
    logic                                   ovf_next;

    logic signed [spmm_pkg::SAMPLE_W-1:0]   right_eff;
    logic signed [spmm_pkg::SAMPLE_W:0]     sum;
    logic signed [spmm_pkg::SAMPLE_W-1:0]   mid;
    logic                                   take;
    logic                                   ovf_now;

    assign right_eff = mono ? left_sample : right_sample;
    assign sum       = {left_sample[spmm_pkg::SAMPLE_W-1], left_sample}
                     + {right_eff[spmm_pkg::SAMPLE_W-1], right_eff};
    // Dropping the low bit of the sum is a floor halving
    assign mid       = sum[spmm_pkg::SAMPLE_W:1];
    assign take      = frame_count_reg < spmm_pkg::MAX_FRAMES;
    assign ovf_now   = ovf_reg | ~take;

    always_comb
    begin
        bundle          = '0;
        bundle.overflow = ovf_now;
        for (int l = 0; l < spmm_pkg::NUM_LEVELS; l++)
        begin
            max_upd[l]  = (take && (mid > max_reg[l])) ? mid : max_reg[l];
            min_upd[l]  = (take && (mid < min_reg[l])) ? mid : min_reg[l];
            fill_upd[l] = fill_reg[l] + {{(spmm_pkg::FILL_W-1){1'b0}}, take};
            bundle.emit[l] = (fill_upd[l] != '0)
                && ((fill_upd[l] >= spmm_pkg::BLOCK_LEN[l]) || end_of_buffer);
            bundle.peak[l].peak_index = pcnt_reg[l];
            bundle.peak[l].max_peak   = max_upd[l];
            bundle.peak[l].min_peak   = min_upd[l];

            if (end_of_buffer)
            begin
                fill_next[l] = '0;
                max_next[l]  = spmm_pkg::PEAK_LOW;
                min_next[l]  = spmm_pkg::PEAK_HIGH;
                pcnt_next[l] = '0;
            end
            else if (bundle.emit[l])
            begin
                fill_next[l] = '0;
                max_next[l]  = spmm_pkg::PEAK_LOW;
                min_next[l]  = spmm_pkg::PEAK_HIGH;
                pcnt_next[l] = pcnt_reg[l] + 1'b1;
            end
            else
            begin
                fill_next[l] = fill_upd[l];
                max_next[l]  = max_upd[l];
                min_next[l]  = min_upd[l];
                pcnt_next[l] = pcnt_reg[l];
            end
        end

        if (end_of_buffer)
        begin
            frame_count_next = '0;
            ovf_next         = 1'b0;
        end
        else
        begin
            frame_count_next = frame_count_reg
                + {{(spmm_pkg::FRAME_W-1){1'b0}}, take};
            ovf_next         = ovf_now;
        end
    end

    assign push = accept & (|bundle.emit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < spmm_pkg::NUM_LEVELS; l++)
            begin
                fill_reg[l] <= '0;
                max_reg[l]  <= spmm_pkg::PEAK_LOW;
                min_reg[l]  <= spmm_pkg::PEAK_HIGH;
                pcnt_reg[l] <= '0;
            end
            frame_count_reg <= '0;
            ovf_reg         <= 1'b0;
        end
        else if (accept)
        begin
            for (int l = 0; l < spmm_pkg::NUM_LEVELS; l++)
            begin
                fill_reg[l] <= fill_next[l];
                max_reg[l]  <= max_next[l];
                min_reg[l]  <= min_next[l];
                pcnt_reg[l] <= pcnt_next[l];
            end
            frame_count_reg <= frame_count_next;
            ovf_reg         <= ovf_next;
        end
    end

    // The closing frame leaves a fresh buffer behind
    a_eob_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_buffer |=> (frame_count_reg == '0) && !ovf_reg)
        else $error("buffer state not cleared after end of buffer");

endmodule

`default_nettype wire

FILE: hw/rtl/spmm_queue.sv
// Short bundle queue between the front and back ends, held in flip-flops.
// Depends on spmm_pkg.
`default_nettype none

module spmm_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire spmm_pkg::spmm_bundle_t  push_data,
    input  wire logic                    pop,
    output spmm_pkg::spmm_bundle_t       head,
    output spmm_pkg::spmm_q_stat_t       stat
);

    spmm_pkg::spmm_bundle_t          entry_reg [spmm_pkg::Q_DEPTH];
    logic [spmm_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [spmm_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [spmm_pkg::Q_CNT_W-1:0]    count_reg;
    logic [spmm_pkg::Q_CNT_W-1:0]    count_next;

    assign head           = entry_reg[rd_ptr_reg];
    assign stat.full      = count_reg == spmm_pkg::Q_CNT_W'(spmm_pkg::Q_DEPTH);
    assign stat.not_empty = count_reg != '0;

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full))
        else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !stat.not_empty))
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

FILE: hw/rtl/spmm_back.sv
// Back end: splits each queued bundle into single results in ascending level
// and holds them in the output register. Depends on spmm_pkg.
`default_nettype none

module spmm_back (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire spmm_pkg::spmm_bundle_t                  head,
    input  wire spmm_pkg::spmm_q_stat_t                  q_stat,
    output logic                                         pop,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output logic [spmm_pkg::LEVEL_W-1:0]                 level,
    output logic [spmm_pkg::PEAK_IDX_W-1:0]              peak_index,
    output logic signed [spmm_pkg::SAMPLE_W-1:0]         max_peak,
    output logic signed [spmm_pkg::SAMPLE_W-1:0]         min_peak,
    output logic                                         overflow,
    output logic                                         last
);

    logic [spmm_pkg::NUM_LEVELS-1:0]   done_reg;
    logic [spmm_pkg::NUM_LEVELS-1:0]   remaining;
    logic [spmm_pkg::NUM_LEVELS-1:0]   sel_mask;
    logic [spmm_pkg::LEVEL_W-1:0]      sel;
    logic                              sel_last;
    logic                              load;
    logic                              out_valid_reg;
    logic [spmm_pkg::LEVEL_W-1:0]      level_reg;
    spmm_pkg::spmm_peak_t              peak_reg;
    logic                              overflow_reg;
    logic                              last_reg;

    assign remaining = head.emit & ~done_reg;

    // Lowest pending level goes first
    always_comb
    begin
        sel      = '0;
        sel_mask = '0;
        for (int l = spmm_pkg::NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (remaining[l])
            begin
                sel      = spmm_pkg::LEVEL_W'(l);
                sel_mask = spmm_pkg::NUM_LEVELS'(1) << l;
            end
        end
    end

    assign sel_last = (remaining & ~sel_mask) == '0;
    assign load     = q_stat.not_empty && (!out_valid_reg || !out_stall);
    assign pop      = load && sel_last;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            level_reg    <= sel;
            peak_reg     <= head.peak[sel];
            overflow_reg <= head.overflow;
            last_reg     <= sel_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (pop)
                done_reg <= '0;
            else if (load)
                done_reg <= done_reg | sel_mask;
        end
    end

    assign out_valid  = out_valid_reg;
    assign level      = level_reg;
    assign peak_index = peak_reg.peak_index;
    assign max_peak   = peak_reg.max_peak;
    assign min_peak   = peak_reg.min_peak;
    assign overflow   = overflow_reg;
    assign last       = last_reg;

    a_sel_pending: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (remaining & sel_mask) != '0)
        else $error("result loaded for a level with nothing pending");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for stereo_peak_mipmap_builder: directed frames and a
// random phase of short and longer buffers under random back-pressure.
// Depends on spmm_pkg and the block's RTL only.
`timescale 1ns / 100ps

module testbench;

    // Own copy of the block geometry for the peak predictor
    localparam logic [2:0][12:0] BLOCK_SIZE     = {13'd4096, 13'd512, 13'd64};
    localparam int               MAX_BUF_FRAMES = 1048576;
    localparam int               SETTLE_CYCLES  = 8;   // covers the block's latency plus queue depth
    localparam int               RANDOM_FRAMES  = 430;
    localparam int               NROWS          = 16;

    // One result transaction: a min/max pair for one level
    typedef struct packed {
        logic [spmm_pkg::LEVEL_W-1:0]         level;
        logic [spmm_pkg::PEAK_IDX_W-1:0]      index;
        logic signed [spmm_pkg::SAMPLE_W-1:0] hi;
        logic signed [spmm_pkg::SAMPLE_W-1:0] lo;
        logic                                 ovf;
        logic                                 last;
    } peak_t;

    // Directed row; typed rows open and close a buffer in one frame, so all three
    // levels report index 0 with max = min = mid
    typedef struct packed {
        logic                                 mono;
        logic signed [spmm_pkg::SAMPLE_W-1:0] left;
        logic signed [spmm_pkg::SAMPLE_W-1:0] right;
        logic                                 eob;
        logic                                 typed;
        logic signed [spmm_pkg::SAMPLE_W-1:0] mid;
    } stim_row_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [2:0]                           paddr;
    logic [31:0]                          pwdata;
    logic [31:0]                          prdata;
    logic                                 pready;
    logic                                 in_valid;
    logic                                 in_stall;
    logic signed [spmm_pkg::SAMPLE_W-1:0] left_sample;
    logic signed [spmm_pkg::SAMPLE_W-1:0] right_sample;
    logic                                 end_of_buffer;
    logic                                 out_valid;
    logic                                 out_stall;
    logic [spmm_pkg::LEVEL_W-1:0]         level;
    logic [spmm_pkg::PEAK_IDX_W-1:0]      peak_index;
    logic signed [spmm_pkg::SAMPLE_W-1:0] max_peak;
    logic signed [spmm_pkg::SAMPLE_W-1:0] min_peak;
    logic                                 overflow;
    logic                                 last;

    // Predictor state: mirrors the block's per-level trackers and buffer counters
    logic                                 mono_cfg;
    int                                   lvl_fill [spmm_pkg::NUM_LEVELS];
    logic signed [spmm_pkg::SAMPLE_W-1:0] lvl_max [spmm_pkg::NUM_LEVELS];
    logic signed [spmm_pkg::SAMPLE_W-1:0] lvl_min [spmm_pkg::NUM_LEVELS];
    logic [spmm_pkg::PEAK_IDX_W-1:0]      lvl_index [spmm_pkg::NUM_LEVELS];
    int                                   buf_frames;
    logic                                 buf_overflow;

    peak_t                                peaks_due [$];
    stim_row_t                            directed_rows [0:NROWS-1];

    int                                   frames_sent;
    int                                   peaks_seen;
    int                                   mismatches;

    stereo_peak_mipmap_builder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .end_of_buffer (end_of_buffer),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .level         (level),
        .peak_index    (peak_index),
        .max_peak      (max_peak),
        .min_peak      (min_peak),
        .overflow      (overflow),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: a run still going at this time is reported as failed
    initial
    begin
        #(2_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Drop the level back to its starting extremes (most negative / most positive)
    function automatic void clear_level(input int lv);
        lvl_fill[lv] = 0;
        lvl_max[lv]  = 16'sh8000;
        lvl_min[lv]  = 16'sh7FFF;
    endfunction

    function automatic void clear_buffer();
        for (int lv = 0; lv < spmm_pkg::NUM_LEVELS; lv++)
        begin
            clear_level(lv);
            lvl_index[lv] = '0;
        end
        buf_frames   = 0;
        buf_overflow = 1'b0;
    endfunction

    // Advance the predictor by one accepted frame; queue its peaks when publish is set
    function automatic void mipmap_predict(input logic signed [spmm_pkg::SAMPLE_W-1:0] l,
                                           input logic signed [spmm_pkg::SAMPLE_W-1:0] r,
                                           input logic eob, input logic publish);
        logic signed [spmm_pkg::SAMPLE_W:0]   sum;
        logic signed [spmm_pkg::SAMPLE_W-1:0] mid;
        logic                                 take;
        peak_t                                pk;
        peak_t                                batch [$];
        sum = mono_cfg ? (l + l) : (l + r);
        // floor halving: drop the low bit of the 17-bit sum
        mid = sum[spmm_pkg::SAMPLE_W:1];
        if (buf_frames >= MAX_BUF_FRAMES)
        begin
            take         = 1'b0;
            buf_overflow = 1'b1;
        end
        else
        begin
            take       = 1'b1;
            buf_frames = buf_frames + 1;
        end
        for (int lv = 0; lv < spmm_pkg::NUM_LEVELS; lv++)
        begin
            if (take)
            begin
                if (mid > lvl_max[lv]) lvl_max[lv] = mid;
                if (mid < lvl_min[lv]) lvl_min[lv] = mid;
                lvl_fill[lv] = lvl_fill[lv] + 1;
            end
            if (lvl_fill[lv] != 0 && (lvl_fill[lv] >= int'(BLOCK_SIZE[lv]) || eob))
            begin
                pk.level = spmm_pkg::LEVEL_W'(lv);
                pk.index = lvl_index[lv];
                pk.hi    = lvl_max[lv];
                pk.lo    = lvl_min[lv];
                pk.ovf   = buf_overflow;
                pk.last  = 1'b0;
                batch.insert(batch.size(), pk);
                lvl_index[lv] = lvl_index[lv] + 1'b1;
                clear_level(lv);
            end
        end
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        if (publish)
            foreach (batch[i])
                peaks_due.insert(peaks_due.size(), batch[i]);
        if (eob)
            clear_buffer();
    endfunction

    function automatic void flag_mismatch(input string field, input int want, input int got);
        mismatches = mismatches + 1;
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
    endfunction

    // Biased sample: a fifth of draws land on the full-scale extremes
    function automatic logic signed [spmm_pkg::SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return spmm_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // Present one frame after a random idle gap (possibly none) and hold it until the block takes it.
    // Typed frames get their three results from the row, not from the predictor.
    task automatic send_frame(input logic signed [spmm_pkg::SAMPLE_W-1:0] l,
                              input logic signed [spmm_pkg::SAMPLE_W-1:0] r,
                              input logic eob, input logic typed,
                              input logic signed [spmm_pkg::SAMPLE_W-1:0] typed_mid);
        int    gap;
        peak_t pk;
        gap = $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      = 1'b1;
        left_sample   = l;
        right_sample  = r;
        end_of_buffer = eob;
        do @(posedge clk); while (in_stall);
        frames_sent = frames_sent + 1;
        mipmap_predict(l, r, eob, !typed);
        if (typed)
            for (int lv = 0; lv < spmm_pkg::NUM_LEVELS; lv++)
            begin
                pk.level = spmm_pkg::LEVEL_W'(lv);
                pk.index = '0;
                pk.hi    = typed_mid;
                pk.lo    = typed_mid;
                pk.ovf   = 1'b0;
                pk.last  = (lv == spmm_pkg::NUM_LEVELS - 1);
                peaks_due.insert(peaks_due.size(), pk);
            end
    endtask

    // Wait for every outstanding peak, then cover frames that give no result
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (peaks_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write (setup + access) followed by a read-back of the same word
    task automatic write_mono(input logic value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 3'(spmm_pkg::REG_MONO_INPUT) << 2;
        pwdata  = {31'd0, value};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        mono_cfg = value;
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[0] !== value)
            flag_mismatch("mono_input", int'(value), int'(prdata[0]));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Result side: stall for a random number of cycles before each transaction
    initial
    begin
        int w;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = $urandom_range(0, 7);
            if (w > 0)
            begin
                @(negedge clk);
                out_stall = 1'b1;
                repeat (w - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall = 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Check each accepted result against the oldest outstanding peak
    always @(posedge clk)
    begin
        peak_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            peaks_seen = peaks_seen + 1;
            if (peaks_due.size() == 0)
            begin
                mismatches = mismatches + 1;
                $error("unexpected result transaction at level %0d index %0d",
                       level, peak_index);
            end
            else
            begin
                want = peaks_due.pop_front();
                if (level !== want.level)
                    flag_mismatch("level", int'(want.level), int'(level));
                if (peak_index !== want.index)
                    flag_mismatch("peak_index", int'(want.index), int'(peak_index));
                if (max_peak !== want.hi)
                    flag_mismatch("max_peak", int'(want.hi), int'(max_peak));
                if (min_peak !== want.lo)
                    flag_mismatch("min_peak", int'(want.lo), int'(min_peak));
                if (overflow !== want.ovf)
                    flag_mismatch("overflow", int'(want.ovf), int'(overflow));
                if (last !== want.last)
                    flag_mismatch("last", int'(want.last), int'(last));
            end
        end
    end

    initial
    begin
        int len;
        int random_frames;
        // Hold every input at a known value from time zero
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        left_sample   = '0;
        right_sample  = '0;
        end_of_buffer = 1'b0;
        frames_sent   = 0;
        peaks_seen    = 0;
        mismatches    = 0;
        mono_cfg      = 1'b0;
        clear_buffer();

        // Full scale, floor rounding of odd negative sums, mono ignoring right,
        // a multi-frame partial buffer in each mode
        directed_rows = '{
            '{1'b0, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, 16'sh7FFF},
            '{1'b0, 16'sh8000, 16'sh8000, 1'b1, 1'b1, 16'sh8000},
            '{1'b0, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1, -16'sd1},
            '{1'b0, -16'sd1,   16'sd0,    1'b1, 1'b1, -16'sd1},
            '{1'b0, 16'sd1,    16'sd0,    1'b1, 1'b1, 16'sd0},
            '{1'b0, 16'sd12345, -16'sd12346, 1'b1, 1'b1, -16'sd1},
            '{1'b0, 16'sd0,    16'sd0,    1'b0, 1'b0, 16'sd0},
            '{1'b0, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 16'sd0},
            '{1'b0, 16'sh8000, 16'sh8000, 1'b0, 1'b0, 16'sd0},
            '{1'b0, 16'sd300,  -16'sd301, 1'b1, 1'b0, 16'sd0},
            '{1'b1, 16'sd100,  16'sh8000, 1'b1, 1'b1, 16'sd100},
            '{1'b1, 16'sh8000, 16'sh7FFF, 1'b1, 1'b1, 16'sh8000},
            '{1'b1, 16'sh7FFF, 16'sd0,    1'b1, 1'b1, 16'sh7FFF},
            '{1'b1, -16'sd2,   16'sd5,    1'b0, 1'b0, 16'sd0},
            '{1'b1, 16'sd7,    16'sh8000, 1'b1, 1'b0, 16'sd0},
            '{1'b0, -16'sd5,   -16'sd6,   1'b1, 1'b1, -16'sd6}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table; switch mono only once the block has drained
        for (int i = 0; i < NROWS; i++)
        begin
            if (directed_rows[i].mono !== mono_cfg)
            begin
                settle();
                write_mono(directed_rows[i].mono);
            end
            send_frame(directed_rows[i].left, directed_rows[i].right,
                       directed_rows[i].eob, directed_rows[i].typed,
                       directed_rows[i].mid);
        end
        settle();
        write_mono(1'b0);

        // Random buffers: mostly short, some long enough to fill level-0 blocks
        random_frames = 0;
        while (random_frames < RANDOM_FRAMES)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                settle();
                write_mono(~mono_cfg);
            end
            else if ($urandom_range(0, 7) == 0)
                settle();   // starve the input until every peak is out
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                              : $urandom_range(1, 30);
            if (len > RANDOM_FRAMES - random_frames)
                len = RANDOM_FRAMES - random_frames;
            for (int k = 1; k <= len; k++)
                send_frame(draw_sample(), draw_sample(), k == len, 1'b0, 16'sd0);
            random_frames = random_frames + len;
        end
        settle();
        write_mono(1'b1);
        settle();
        write_mono(1'b0);
        settle();

        $display("Run covered %0d frames and %0d peak results,",
                 frames_sent, peaks_seen);
        $display("with both mono settings, full-scale samples and random back-pressure.");
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
